// ===== rtl/core/stack_machine_executor_defines.svh =====
// Assertion macros shared by the stack machine executor checker.
// Plain text macros only; no dependencies.
`ifndef STACK_MACHINE_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sme_checker: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define SME_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sme_checker: property failed");

`endif

// ===== rtl/core/sme_pkg.sv =====
// Shared types, codes and defaults of the stack machine executor.
// No dependencies; compile first.
`timescale 1ns / 1ps

package sme_pkg;

	// Fixed field widths of the request and result channels.
	localparam int CMD_W    = 4;
	localparam int KIND_W   = 3;
	localparam int IMM_W    = 32;
	localparam int POPCNT_W = 9;
	localparam int PC_W     = 16;
	localparam int STATUS_W = 3;
	localparam int TOPV_W   = 32;

	// Default sizes handed to the top level.
	localparam int DEF_STACK_DEPTH  = 256;
	localparam int DEF_RETURN_DEPTH = 64;
	localparam int DEF_VALUE_WIDTH  = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_INT  = 4'd0,
		CMD_PUSH_BOOL = 4'd1,
		CMD_POP       = 4'd2,
		CMD_POP_MANY  = 4'd3,
		CMD_ADD       = 4'd4,
		CMD_SUB       = 4'd5,
		CMD_CMP       = 4'd6,
		CMD_BRN       = 4'd7,
		CMD_JMP       = 4'd8,
		CMD_GOSUB     = 4'd9,
		CMD_RET       = 4'd10,
		CMD_SWAP      = 4'd11
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		CMP_LE = 3'd0,
		CMP_LT = 3'd1,
		CMP_GE = 3'd2,
		CMP_GT = 3'd3,
		CMP_NE = 3'd4,
		CMP_EQ = 3'd5
	} cmp_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_UNDER     = 3'd1,
		ST_TYPE      = 3'd2,
		ST_OVER      = 3'd3,
		ST_RET_EMPTY = 3'd4,
		ST_RET_FULL  = 3'd5,
		ST_INVALID   = 3'd6
	} status_t;

endpackage

// ===== rtl/core/sme_if.sv =====
// Valid/ready channel interfaces of the stack machine executor.
// Depends on sme_pkg for the field widths.
`timescale 1ns / 1ps

// Instruction request channel.
interface sme_instr_if;
	import sme_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [CMD_W-1:0]           cmd;
	logic [KIND_W-1:0]          cmp_kind;
	logic signed [IMM_W-1:0]    immediate;
	logic [POPCNT_W-1:0]        pop_count;
	logic [PC_W-1:0]            target;

	modport source (output valid, cmd, cmp_kind, immediate, pop_count, target, input ready);
	modport sink (input valid, cmd, cmp_kind, immediate, pop_count, target, output ready);
endinterface

// Result channel, one result per instruction.
interface sme_result_if;
	import sme_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [PC_W-1:0]            next_pc;
	logic                       done_res;
	logic [STATUS_W-1:0]        status;
	logic signed [TOPV_W-1:0]   top_value;

	modport source (output valid, next_pc, done_res, status, top_value, input ready);
	modport sink (input valid, next_pc, done_res, status, top_value, output ready);
endinterface

// Configuration write channel for the program length register.
interface sme_cfg_if;
	import sme_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [PC_W-1:0]            program_length;

	modport source (output valid, program_length, input ready);
	modport sink (input valid, program_length, output ready);
endinterface

// ===== rtl/core/sme_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/stack_machine_executor.sv =====
// Stack machine executor: one instruction per request on a typed data stack and a return stack.
// Depends on sme_pkg, the channel interfaces in sme_if.sv and sme_ram.
`timescale 1ns / 1ps

// The block executes one instruction per clock cycle, back to back, as long as results are
// taken. A request is captured in an input register, executed from there once the result
// register is free or being taken, and its result is registered before it is offered. The
// two top data entries and the top return address are kept in registers; deeper entries
// live in RAM, written when an entry sinks below the top pair and read back (one registered
// read) when the stack shrinks, so that no instruction waits for the RAM. The stacks need
// no clearing after reset, so requests are accepted from the first cycle. The user must
// write the program length register through the configuration channel, which is always
// ready, only while no instruction is in flight; the block itself does not enforce this.
module stack_machine_executor #(
	parameter int STACK_DEPTH  = sme_pkg::DEF_STACK_DEPTH,
	parameter int RETURN_DEPTH = sme_pkg::DEF_RETURN_DEPTH,
	parameter int VALUE_WIDTH  = sme_pkg::DEF_VALUE_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	sme_instr_if.sink  instr,
	sme_result_if.source result,
	sme_cfg_if.sink    cfg
);
	import sme_pkg::*;

	localparam int VW       = VALUE_WIDTH;
	localparam int EW       = VALUE_WIDTH + 1;
	localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
	localparam int SA_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int RDEPTH_W = $clog2(RETURN_DEPTH + 1);
	localparam int RA_W     = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
	localparam int CNT_W    = (DEPTH_W > POPCNT_W) ? DEPTH_W : POPCNT_W;

	// Sign-extend or truncate a stack value to the result field.
	function automatic logic [TOPV_W-1:0] to_top(input logic [VW-1:0] v);
		logic signed [63:0] w;
		w = 64'($signed(v));
		return w[TOPV_W-1:0];
	endfunction

	// Input register.
	logic                    valid_s1;
	logic [CMD_W-1:0]        cmd_s1;
	logic [KIND_W-1:0]       kind_s1;
	logic signed [IMM_W-1:0] imm_s1;
	logic [POPCNT_W-1:0]     cnt_s1;
	logic [PC_W-1:0]         target_s1;

	// Architectural state.
	logic [DEPTH_W-1:0]  depth_q;
	logic [VW-1:0]       top_val_q, nos_val_q;
	logic                top_bool_q, nos_bool_q;
	logic                top_ram_q, nos_ram_q;
	logic [RDEPTH_W-1:0] rdepth_q;
	logic [PC_W-1:0]     rtop_q;
	logic                rtop_ram_q;
	logic [PC_W-1:0]     pc_q;
	logic [PC_W-1:0]     plen_q;

	// Result register.
	logic                out_valid_q;
	logic [PC_W-1:0]     next_pc_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [TOPV_W-1:0]   out_top_q;
	logic                out_top_ram_q;

	// RAM read data.
	logic [EW-1:0]   rd0, rd1;
	logic [PC_W-1:0] rrd;

	// Current view of the stack tops.
	logic [VW-1:0]   top_v, nos_v;
	logic            top_b, nos_b;
	logic [PC_W-1:0] rtop_cur;

	// Next-state values.
	status_t             st_n;
	logic [PC_W-1:0]     exec_pc;
	logic [PC_W-1:0]     pc_n;
	logic [DEPTH_W-1:0]  depth_n;
	logic [VW-1:0]       top_v_n, nos_v_n;
	logic                top_b_n, nos_b_n;
	logic                top_ram_n, nos_ram_n;
	logic                dwe;
	logic [RDEPTH_W-1:0] rdepth_n;
	logic [PC_W-1:0]     rtop_n;
	logic                rtop_ram_n;
	logic                rwe;

	// Helpers.
	logic                advance;
	logic                accept;
	logic [PC_W-1:0]     inc;
	logic [CNT_W-1:0]    pop_n;
	logic [VW-1:0]       imm_v;
	logic signed [63:0]  imm64;
	logic [VW-1:0]       sum_v, diff_v;
	logic                lt_s, eq_s, cmp_res, kind_ok;
	logic                full, ge2;
	logic [DEPTH_W-1:0]  dm2, dra0_full, dra1_full;
	logic [RDEPTH_W-1:0] rm1, rra_full;

	// Handshake: the result register frees the pipeline as soon as it is taken.
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign instr.ready  = !valid_s1 || advance;
	assign accept       = instr.valid && instr.ready;
	assign cfg.ready    = 1'b1;

	// Top entries come from RAM read data in the cycle after the stack shrinks.
	assign top_v    = top_ram_q ? rd0[VW-1:0] : top_val_q;
	assign top_b    = top_ram_q ? rd0[VW] : top_bool_q;
	assign nos_v    = nos_ram_q ? rd1[VW-1:0] : nos_val_q;
	assign nos_b    = nos_ram_q ? rd1[VW] : nos_bool_q;
	assign rtop_cur = rtop_ram_q ? rrd : rtop_q;

	// Operand preparation.
	assign inc     = pc_q + PC_W'(1);
	assign imm64   = 64'(imm_s1);
	assign imm_v   = imm64[VW-1:0];
	assign sum_v   = nos_v + top_v;
	assign diff_v  = nos_v - top_v;
	assign lt_s    = $signed(nos_v) < $signed(top_v);
	assign eq_s    = nos_v == top_v;
	assign full    = depth_q == DEPTH_W'(STACK_DEPTH);
	assign ge2     = depth_q >= DEPTH_W'(2);
	assign pop_n   = (cmd_s1 == CMD_POP) ? CNT_W'(1) : CNT_W'(cnt_s1);
	assign dm2     = depth_q - DEPTH_W'(2);
	assign rm1     = rdepth_q - RDEPTH_W'(1);

	// Signed compare of below-top against top.
	always_comb begin
		kind_ok = 1'b1;
		case (kind_s1)
			CMP_LE:  cmp_res = lt_s || eq_s;
			CMP_LT:  cmp_res = lt_s;
			CMP_GE:  cmp_res = !lt_s;
			CMP_GT:  cmp_res = !(lt_s || eq_s);
			CMP_NE:  cmp_res = !eq_s;
			CMP_EQ:  cmp_res = eq_s;
			default: begin
				cmp_res = 1'b0;
				kind_ok = 1'b0;
			end
		endcase
	end

	// Instruction execution. Failing instructions change nothing but the status.
	always_comb begin
		st_n       = ST_OK;
		exec_pc    = inc;
		depth_n    = depth_q;
		top_v_n    = top_v;
		top_b_n    = top_b;
		nos_v_n    = nos_v;
		nos_b_n    = nos_b;
		top_ram_n  = 1'b0;
		nos_ram_n  = 1'b0;
		dwe        = 1'b0;
		rdepth_n   = rdepth_q;
		rtop_n     = rtop_cur;
		rtop_ram_n = 1'b0;
		rwe        = 1'b0;
		if (advance) begin
			case (cmd_s1)
				CMD_PUSH_INT, CMD_PUSH_BOOL: begin
					if (full) begin
						st_n = ST_OVER;
					end else begin
						top_v_n = (cmd_s1 == CMD_PUSH_INT) ? imm_v : VW'(imm_s1 != 0);
						top_b_n = (cmd_s1 == CMD_PUSH_BOOL);
						nos_v_n = top_v;
						nos_b_n = top_b;
						dwe     = ge2;
						depth_n = depth_q + DEPTH_W'(1);
					end
				end
				CMD_POP, CMD_POP_MANY: begin
					if (pop_n > CNT_W'(depth_q)) begin
						st_n = ST_UNDER;
					end else begin
						depth_n = depth_q - pop_n[DEPTH_W-1:0];
						if (pop_n == CNT_W'(1)) begin
							top_v_n   = nos_v;
							top_b_n   = nos_b;
							nos_ram_n = 1'b1;
						end else if (pop_n != '0) begin
							top_ram_n = depth_n != '0;
							nos_ram_n = 1'b1;
						end
					end
				end
				CMD_ADD, CMD_SUB: begin
					if (!ge2) begin
						st_n = ST_UNDER;
					end else if (top_b || nos_b) begin
						st_n = ST_TYPE;
					end else begin
						top_v_n   = (cmd_s1 == CMD_ADD) ? sum_v : diff_v;
						top_b_n   = 1'b0;
						nos_ram_n = 1'b1;
						depth_n   = depth_q - DEPTH_W'(1);
					end
				end
				CMD_CMP: begin
					if (!ge2) begin
						st_n = ST_UNDER;
					end else if (top_b || nos_b) begin
						st_n = ST_TYPE;
					end else if (!kind_ok) begin
						st_n = ST_INVALID;
					end else if (full) begin
						st_n = ST_OVER;
					end else begin
						top_v_n = VW'(cmp_res);
						top_b_n = 1'b1;
						nos_v_n = top_v;
						nos_b_n = top_b;
						dwe     = 1'b1;
						depth_n = depth_q + DEPTH_W'(1);
					end
				end
				CMD_BRN: begin
					if (depth_q == '0) begin
						st_n = ST_UNDER;
					end else if (!top_b) begin
						st_n = ST_TYPE;
					end else if (top_v != '0) begin
						exec_pc = target_s1;
					end
				end
				CMD_JMP: begin
					exec_pc = target_s1;
				end
				CMD_GOSUB: begin
					if (rdepth_q == RDEPTH_W'(RETURN_DEPTH)) begin
						st_n = ST_RET_FULL;
					end else begin
						rwe      = rdepth_q != '0;
						rtop_n   = inc;
						rdepth_n = rdepth_q + RDEPTH_W'(1);
						exec_pc  = target_s1;
					end
				end
				CMD_RET: begin
					if (rdepth_q == '0) begin
						st_n = ST_RET_EMPTY;
					end else begin
						exec_pc    = rtop_cur;
						rdepth_n   = rm1;
						rtop_ram_n = 1'b1;
					end
				end
				CMD_SWAP: begin
					if (!ge2) begin
						st_n = ST_UNDER;
					end else begin
						top_v_n = nos_v;
						top_b_n = nos_b;
						nos_v_n = top_v;
						nos_b_n = top_b;
					end
				end
				default: begin
					st_n = ST_INVALID;
				end
			endcase
			if (st_n != ST_OK) begin
				exec_pc = pc_q;
			end
		end
	end

	assign pc_n      = advance ? exec_pc : pc_q;
	assign dra0_full = depth_n - DEPTH_W'(1);
	assign dra1_full = depth_n - DEPTH_W'(2);
	assign rra_full  = rdepth_n - RDEPTH_W'(1);

	// Data stack below the top pair; two copies give the two read ports.
	sme_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_data_ram0 (
		.clk   (clk),
		.we    (dwe),
		.waddr (dm2[SA_W-1:0]),
		.wdata ({nos_b, nos_v}),
		.raddr (dra0_full[SA_W-1:0]),
		.rdata (rd0)
	);

	sme_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_data_ram1 (
		.clk   (clk),
		.we    (dwe),
		.waddr (dm2[SA_W-1:0]),
		.wdata ({nos_b, nos_v}),
		.raddr (dra1_full[SA_W-1:0]),
		.rdata (rd1)
	);

	// Return addresses below the top one.
	sme_ram #(.WIDTH(PC_W), .DEPTH(RETURN_DEPTH)) u_ret_ram (
		.clk   (clk),
		.we    (rwe),
		.waddr (rm1[RA_W-1:0]),
		.wdata (rtop_cur),
		.raddr (rra_full[RA_W-1:0]),
		.rdata (rrd)
	);

	// Control state and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			out_top_ram_q <= 1'b0;
			depth_q       <= '0;
			rdepth_q      <= '0;
			pc_q          <= '0;
			plen_q        <= '0;
			top_ram_q     <= 1'b0;
			nos_ram_q     <= 1'b0;
			rtop_ram_q    <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				out_top_ram_q <= top_ram_n;
			end else begin
				out_top_ram_q <= 1'b0;
			end
			if (cfg.valid) begin
				plen_q <= cfg.program_length;
			end
			depth_q    <= depth_n;
			rdepth_q   <= rdepth_n;
			pc_q       <= pc_n;
			top_ram_q  <= top_ram_n;
			nos_ram_q  <= nos_ram_n;
			rtop_ram_q <= rtop_ram_n;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= instr.cmd;
			kind_s1   <= instr.cmp_kind;
			imm_s1    <= instr.immediate;
			cnt_s1    <= instr.pop_count;
			target_s1 <= instr.target;
		end
		top_val_q  <= top_v_n;
		top_bool_q <= top_b_n;
		nos_val_q  <= nos_v_n;
		nos_bool_q <= nos_b_n;
		rtop_q     <= rtop_n;
		if (advance) begin
			next_pc_q <= exec_pc;
			done_q    <= exec_pc >= plen_q;
			status_q  <= st_n;
			if (depth_n == '0) begin
				out_top_q <= '0;
			end else begin
				out_top_q <= to_top(top_v_n);
			end
		end else if (out_top_ram_q) begin
			// Capture the refilled top before the RAM read data moves on.
			out_top_q <= to_top(top_v);
		end
	end

	// Result channel.
	assign result.valid     = out_valid_q;
	assign result.next_pc   = next_pc_q;
	assign result.done_res  = done_q;
	assign result.status    = status_q;
	assign result.top_value = out_top_ram_q ? to_top(rd0[VW-1:0]) : out_top_q;

endmodule

// ===== rtl/core/sme_checker.sv =====
// Port-level checker of the stack machine executor, attached by bind.
// Depends on sme_pkg and the macros in stack_machine_executor_defines.svh.
`timescale 1ns / 1ps
`include "stack_machine_executor_defines.svh"

module sme_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         instr_valid,
	input logic                         instr_ready,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [sme_pkg::PC_W-1:0]     next_pc,
	input logic                         done_res,
	input logic [sme_pkg::STATUS_W-1:0] status,
	input logic [sme_pkg::TOPV_W-1:0]   top_value,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic [sme_pkg::PC_W-1:0]     cfg_program_length
);
	import sme_pkg::*;

	logic [PC_W-1:0] plen_q;
	logic [2:0]      pending_q;

	// Shadow of the program length and count of requests without a delivered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q    <= '0;
			pending_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				plen_q <= cfg_program_length;
			end
			pending_q <= pending_q + 3'(instr_valid && instr_ready)
				- 3'(result_valid && result_ready);
		end
	end

	// At most the input register and the result register hold work.
	`SME_ASSERT_IMP(a_pending_bound, clk, arst_n, 1'b1, pending_q <= 3'd2)

	// Every offered result belongs to an accepted request.
	`SME_ASSERT_IMP(a_result_has_request, clk, arst_n, result_valid, pending_q != 3'd0)

	// The done flag reports the position against the program length.
	`SME_ASSERT_IMP(a_done_flag, clk, arst_n, result_valid, done_res == (next_pc >= plen_q))

	// A stalled result holds its position, its status and its top value.
	`SME_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready,
		result_valid && $stable(next_pc) && $stable(top_value) && $stable(status))

endmodule

bind stack_machine_executor sme_checker u_sme_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.instr_valid        (instr.valid),
	.instr_ready        (instr.ready),
	.result_valid       (result.valid),
	.result_ready       (result.ready),
	.next_pc            (result.next_pc),
	.done_res           (result.done_res),
	.status             (result.status),
	.top_value          (result.top_value),
	.cfg_valid          (cfg.valid),
	.cfg_ready          (cfg.ready),
	.cfg_program_length (cfg.program_length)
);
